// ===== src/jrp_pkg.sv =====
package jrp_pkg;

  localparam int COORD_W = 16;

  localparam logic signed [COORD_W-1:0] CRD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] CRD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic [COORD_W:0] SLOW_STEP = (COORD_W+1)'(1);
  localparam logic [COORD_W:0] FAST_STEP = (COORD_W+1)'(10);

  typedef logic signed [COORD_W-1:0] coord_t;

  // request types
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_KEY    = 2'd1;
  localparam logic [1:0] REQ_TOGGLE = 2'd2;
  localparam logic [1:0] REQ_LOAD   = 2'd3;

  // command codes (pending command and last jog)
  localparam logic [3:0] CMD_NONE   = 4'd0;
  localparam logic [3:0] CMD_SLOW_L = 4'd1;
  localparam logic [3:0] CMD_SLOW_R = 4'd2;
  localparam logic [3:0] CMD_SLOW_U = 4'd3;
  localparam logic [3:0] CMD_SLOW_D = 4'd4;
  localparam logic [3:0] CMD_FAST_L = 4'd5;
  localparam logic [3:0] CMD_FAST_R = 4'd6;
  localparam logic [3:0] CMD_FAST_U = 4'd7;
  localparam logic [3:0] CMD_FAST_D = 4'd8;
  localparam logic [3:0] CMD_OK     = 4'd9;
  localparam logic [3:0] CMD_CANCEL = 4'd10;

  // jog button patterns
  localparam logic [3:0] BTN_UP    = 4'b0001;
  localparam logic [3:0] BTN_DOWN  = 4'b0010;
  localparam logic [3:0] BTN_LEFT  = 4'b0100;
  localparam logic [3:0] BTN_RIGHT = 4'b1000;
  localparam logic [3:0] BTN_UD    = 4'b0011;
  localparam logic [3:0] BTN_LR    = 4'b1100;

  // result status
  localparam logic [1:0] ST_MOVED     = 2'd0;
  localparam logic [1:0] ST_UNCHANGED = 2'd1;
  localparam logic [1:0] ST_ACCEPTED  = 2'd2;
  localparam logic [1:0] ST_CANCELLED = 2'd3;

  // register indexes
  localparam logic [2:0] REG_POINT_MODE   = 3'd0;
  localparam logic [2:0] REG_LIMIT_LEFT   = 3'd1;
  localparam logic [2:0] REG_LIMIT_TOP    = 3'd2;
  localparam logic [2:0] REG_LIMIT_RIGHT  = 3'd3;
  localparam logic [2:0] REG_LIMIT_BOTTOM = 3'd4;

  localparam coord_t LIMIT_RB_RESET = coord_t'(1023);

  typedef struct packed {
    logic   point_mode;
    coord_t limit_left;
    coord_t limit_top;
    coord_t limit_right;
    coord_t limit_bottom;
  } jrp_cfg_t;

  typedef struct packed {
    coord_t     left;
    coord_t     top;
    coord_t     right;
    coord_t     bottom;
    logic       resize;
    logic [3:0] pending;
    logic [3:0] last_jog;
    logic       finished;
  } jrp_state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] jog_buttons;
    logic [3:0] key_cmd;
    coord_t     load_left;
    coord_t     load_top;
    coord_t     load_right;
    coord_t     load_bottom;
  } jrp_in_t;

  typedef struct packed {
    logic [1:0] status;
    coord_t     pos_left;
    coord_t     pos_top;
    coord_t     pos_right;
    coord_t     pos_bottom;
    logic       resize_active;
  } jrp_res_t;

  // Add or subtract a step and clamp to the signed coordinate range.
  function automatic coord_t sat_step(coord_t v, logic neg, logic fast);
    logic [COORD_W:0] ext;
    logic [COORD_W:0] stp;
    logic [COORD_W:0] sum;
    ext = {v[COORD_W-1], v};
    stp = fast ? FAST_STEP : SLOW_STEP;
    sum = neg ? (ext - stp) : (ext + stp);
    if (sum[COORD_W] != sum[COORD_W-1]) begin
      return sum[COORD_W] ? CRD_MIN : CRD_MAX;
    end
    return coord_t'(sum[COORD_W-1:0]);
  endfunction

endpackage

// ===== src/jrp_step.sv =====
module jrp_step (
  input  jrp_pkg::jrp_cfg_t   cfg_i,
  input  jrp_pkg::jrp_state_t state_i,
  input  jrp_pkg::jrp_in_t    req_i,
  output jrp_pkg::jrp_state_t state_o,
  output jrp_pkg::jrp_res_t   res_o
);
  import jrp_pkg::*;

  logic [3:0] c;
  logic [1:0] dir;
  logic       fast;
  logic       horiz;
  logic       neg;
  logic       is_move;
  logic       ok;
  coord_t     hx_lo, hx_hi, vy_lo, vy_hi;
  coord_t     nl, nt, nr, nb;
  logic       changed;
  logic [1:0] cmd_status;
  logic [3:0] jog;
  jrp_state_t nxt;
  logic [1:0] status;

  // Pending command applied at a tick.
  always_comb begin
    c       = state_i.pending;
    dir     = 2'(c - 4'd1);
    fast    = (c >= CMD_FAST_L);
    horiz   = !dir[1];
    neg     = !dir[0];
    is_move = (c >= CMD_SLOW_L) && (c <= CMD_FAST_D);

    hx_lo = (cfg_i.point_mode || !state_i.resize) ? state_i.left : state_i.right;
    hx_hi = cfg_i.point_mode ? state_i.left : state_i.right;
    vy_lo = (cfg_i.point_mode || !state_i.resize) ? state_i.top : state_i.bottom;
    vy_hi = cfg_i.point_mode ? state_i.top : state_i.bottom;

    if (horiz) begin
      ok = neg ? (hx_lo > cfg_i.limit_left) : (hx_hi < cfg_i.limit_right);
    end else begin
      ok = neg ? (vy_lo > cfg_i.limit_top) : (vy_hi < cfg_i.limit_bottom);
    end
    ok = ok && is_move;

    nl = state_i.left;
    nt = state_i.top;
    nr = state_i.right;
    nb = state_i.bottom;
    if (ok && horiz && (cfg_i.point_mode || !state_i.resize)) begin
      nl = sat_step(state_i.left, neg, fast);
    end
    if (ok && horiz && !cfg_i.point_mode) begin
      nr = sat_step(state_i.right, neg, fast);
    end
    if (ok && !horiz && (cfg_i.point_mode || !state_i.resize)) begin
      nt = sat_step(state_i.top, neg, fast);
    end
    if (ok && !horiz && !cfg_i.point_mode) begin
      nb = sat_step(state_i.bottom, neg, fast);
    end

    changed = (nl != state_i.left) || (nt != state_i.top) ||
              (nr != state_i.right) || (nb != state_i.bottom);

    if (c == CMD_OK) begin
      cmd_status = ST_ACCEPTED;
    end else if (c == CMD_CANCEL) begin
      cmd_status = ST_CANCELLED;
    end else if (changed) begin
      cmd_status = ST_MOVED;
    end else begin
      cmd_status = ST_UNCHANGED;
    end
  end

  // Button decode; opposite buttons go fast and keep the last direction.
  always_comb begin
    case (req_i.jog_buttons)
      BTN_UP:    jog = CMD_SLOW_U;
      BTN_DOWN:  jog = CMD_SLOW_D;
      BTN_LEFT:  jog = CMD_SLOW_L;
      BTN_RIGHT: jog = CMD_SLOW_R;
      BTN_UD:    jog = (state_i.last_jog inside {CMD_SLOW_D, CMD_FAST_D}) ?
                       CMD_FAST_D : CMD_FAST_U;
      BTN_LR:    jog = (state_i.last_jog inside {CMD_SLOW_R, CMD_FAST_R}) ?
                       CMD_FAST_R : CMD_FAST_L;
      default:   jog = CMD_NONE;
    endcase
  end

  always_comb begin
    nxt    = state_i;
    status = ST_UNCHANGED;
    unique case (req_i.req_type)
      REQ_TICK: begin
        if (!state_i.finished) begin
          status       = cmd_status;
          nxt.left     = nl;
          nxt.top      = nt;
          nxt.right    = nr;
          nxt.bottom   = nb;
          nxt.finished = cmd_status[1];
          nxt.pending  = jog;
          nxt.last_jog = jog;
        end
      end
      REQ_KEY: begin
        nxt.pending = (req_i.key_cmd <= CMD_CANCEL) ? req_i.key_cmd : CMD_NONE;
      end
      REQ_TOGGLE: begin
        nxt.resize  = !state_i.resize;
        nxt.pending = CMD_NONE;
      end
      REQ_LOAD: begin
        nxt.left     = req_i.load_left;
        nxt.top      = req_i.load_top;
        nxt.right    = req_i.load_right;
        nxt.bottom   = req_i.load_bottom;
        nxt.finished = 1'b0;
        nxt.pending  = CMD_NONE;
        nxt.last_jog = CMD_NONE;
        nxt.resize   = 1'b0;
        status       = ST_MOVED;
      end
    endcase
    state_o = nxt;

    res_o.status        = status;
    res_o.pos_left      = nxt.left;
    res_o.pos_top       = nxt.top;
    res_o.pos_right     = cfg_i.point_mode ? '0 : nxt.right;
    res_o.pos_bottom    = cfg_i.point_mode ? '0 : nxt.bottom;
    res_o.resize_active = cfg_i.point_mode ? 1'b0 : nxt.resize;
  end

endmodule

// ===== src/jog_roi_positioner_top.sv =====
// A result is registered in the output register, or in the skid entry while out_* stalls.
// Throughput: one request per cycle while in_ready is high; the whole step is a compare and add.
// A two-entry result buffer (output register plus skid) keeps in_ready high while one
// result waits, so in_ready drops only when both entries are full.
// Reset (rst_n low, synchronous): box at 0, move mode, no pending command, limits 0/0/1023/1023.
module jog_roi_positioner_top (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_req_type,
  input  logic [3:0]            in_jog_buttons,
  input  logic [3:0]            in_key_cmd,
  input  jrp_pkg::coord_t       in_load_left,
  input  jrp_pkg::coord_t       in_load_top,
  input  jrp_pkg::coord_t       in_load_right,
  input  jrp_pkg::coord_t       in_load_bottom,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output jrp_pkg::coord_t       out_pos_left,
  output jrp_pkg::coord_t       out_pos_top,
  output jrp_pkg::coord_t       out_pos_right,
  output jrp_pkg::coord_t       out_pos_bottom,
  output logic                  out_resize_active,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import jrp_pkg::*;

  jrp_cfg_t   cfg_r;
  jrp_state_t state_r;
  jrp_state_t state_nxt;
  jrp_in_t    req;
  jrp_res_t   res;
  jrp_res_t   out_r, out_nxt;
  jrp_res_t   skid_r;
  logic       out_valid_r, out_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  logic       push, pop;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  // ---------------------------------------------------------------------------
  // Configuration: zero wait states, write on the access phase.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.point_mode   <= 1'b0;
      cfg_r.limit_left   <= '0;
      cfg_r.limit_top    <= '0;
      cfg_r.limit_right  <= LIMIT_RB_RESET;
      cfg_r.limit_bottom <= LIMIT_RB_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_POINT_MODE:   cfg_r.point_mode   <= pwdata[0];
        REG_LIMIT_LEFT:   cfg_r.limit_left   <= coord_t'(pwdata[COORD_W-1:0]);
        REG_LIMIT_TOP:    cfg_r.limit_top    <= coord_t'(pwdata[COORD_W-1:0]);
        REG_LIMIT_RIGHT:  cfg_r.limit_right  <= coord_t'(pwdata[COORD_W-1:0]);
        REG_LIMIT_BOTTOM: cfg_r.limit_bottom <= coord_t'(pwdata[COORD_W-1:0]);
        default: ;  // drop writes outside the register map
      endcase
    end
  end

  // Read back; limits come back sign-extended.
  always_comb begin
    unique case (reg_idx)
      REG_POINT_MODE:   prdata = {31'd0, cfg_r.point_mode};
      REG_LIMIT_LEFT:   prdata = 32'(cfg_r.limit_left);
      REG_LIMIT_TOP:    prdata = 32'(cfg_r.limit_top);
      REG_LIMIT_RIGHT:  prdata = 32'(cfg_r.limit_right);
      REG_LIMIT_BOTTOM: prdata = 32'(cfg_r.limit_bottom);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Request handling: state advances at every accepted request.
  // ---------------------------------------------------------------------------
  assign in_ready = !skid_valid_r;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;

  assign req.req_type    = in_req_type;
  assign req.jog_buttons = in_jog_buttons;
  assign req.key_cmd     = in_key_cmd;
  assign req.load_left   = in_load_left;
  assign req.load_top    = in_load_top;
  assign req.load_right  = in_load_right;
  assign req.load_bottom = in_load_bottom;

  jrp_step u_step (
    .cfg_i   (cfg_r),
    .state_i (state_r),
    .req_i   (req),
    .state_o (state_nxt),
    .res_o   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (push) begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result buffer: output register with a skid entry behind it.
  // ---------------------------------------------------------------------------
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || pop) begin
      // advance the skid entry, else take the new result directly
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = push;
      end
    end else if (push) begin
      // output is stalled: park the new result
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (push && out_valid_r && !pop) begin
      skid_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_pos_left      = out_r.pos_left;
  assign out_pos_top       = out_r.pos_top;
  assign out_pos_right     = out_r.pos_right;
  assign out_pos_bottom    = out_r.pos_bottom;
  assign out_resize_active = out_r.resize_active;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register is empty");

  a_finished_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (push && in_req_type == REQ_TICK && state_r.finished) |=>
      ($stable(state_r.left) && $stable(state_r.top) &&
       $stable(state_r.right) && $stable(state_r.bottom)))
    else $error("tick moved the box after the session finished");

  a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (push && in_req_type == REQ_LOAD) |=>
      (!state_r.finished && state_r.pending == CMD_NONE && !state_r.resize))
    else $error("load request did not restart the session");

endmodule
